@@ src/lpd_pkg.sv @@
package lpd_pkg;

  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned OUTQ_DEPTH = 5;
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned HCNT_W     = $clog2(HDR_BYTES);
  localparam int unsigned PUSH_W     = $clog2(HDR_BYTES + 1);

  localparam logic [31:0] MAX_LEN_RST = 32'd3000;

  // Largest fill level at which a full header burst still fits.
  localparam logic [OUTQ_CW-1:0] ACCEPT_LEVEL = OUTQ_CW'(OUTQ_DEPTH - HDR_BYTES);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_HALT    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
    logic       length_error;
  } out_item_t;

endpackage

@@ src/length_prefixed_deframer.sv @@
// Channel   | Ports                            | Moves
// ----------+----------------------------------+---------------------------------------
// input     | in_valid, in_stall, in_data      | one stream byte or a restart request
// output    | out_valid, out_stall, out_data   | one frame byte, or the length error
// config    | cfg_we, cfg_wdata                | max_payload_length, written at once
//
// Flow: a byte is decoded in the cycle it is accepted; its results, if any, are
//   registered into the output queue and reach out_data at its head. Payload
//   bytes flow at one per cycle while in_stall is low. A completed header pushes
//   four results (one length error if too long), so the input stalls while they drain.
// Reset: synchronous on rst_n low; empty queue, header phase, maximum 3000.
// Stalls: in_stall comes from the queue fill level alone (set above one entry),
//   so there is no combinational path from out_stall to in_stall.
module length_prefixed_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lpd_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lpd_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);
  import lpd_pkg::*;

  // Frame state
  phase_t              phase_r, phase_nxt;
  logic [HCNT_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]          hdr_r [HDR_BYTES-1];
  logic                hdr_we;
  logic [31:0]         remaining_r, remaining_nxt;
  logic [31:0]         rem_dec;
  logic [31:0]         frame_len;
  logic [31:0]         max_len_r;

  // Output queue, head at entry zero
  out_item_t           q_r   [OUTQ_DEPTH];
  out_item_t           q_nxt [OUTQ_DEPTH];
  logic [OUTQ_CW-1:0]  cnt_r, cnt_nxt, cnt_after;
  out_item_t           push  [HDR_BYTES];
  logic [PUSH_W-1:0]   npush;

  logic                in_acc;
  logic                out_pop;

  assign in_stall  = (cnt_r > ACCEPT_LEVEL);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign out_data  = q_r[0];

  assign rem_dec   = remaining_r - 32'd1;
  assign frame_len = {hdr_r[0], hdr_r[1], hdr_r[2], in_data.data_byte};

  // Decode one request
  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    remaining_nxt = remaining_r;
    hdr_we        = 1'b0;
    npush         = '0;
    for (int k = 0; k < HDR_BYTES; k++) begin
      push[k] = '0;
    end

    if (in_acc) begin
      if (in_data.restart) begin
        // drop any partial frame and leave the halt
        phase_nxt   = PH_HEADER;
        hdr_cnt_nxt = '0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (hdr_cnt_r == HCNT_W'(HDR_BYTES - 1)) begin
              hdr_cnt_nxt = '0;
              if (frame_len > max_len_r) begin
                push[0].length_error = 1'b1;
                npush                = PUSH_W'(1);
                phase_nxt            = PH_HALT;
              end else begin
                for (int k = 0; k < HDR_BYTES - 1; k++) begin
                  push[k].out_byte = hdr_r[k];
                end
                push[HDR_BYTES-1].out_byte   = in_data.data_byte;
                push[HDR_BYTES-1].frame_last = (frame_len == 32'd0);
                npush                        = PUSH_W'(HDR_BYTES);
                remaining_nxt                = frame_len;
                phase_nxt = (frame_len == 32'd0) ? PH_HEADER : PH_PAYLOAD;
              end
            end else begin
              // hold the header byte until the length is complete
              hdr_we      = 1'b1;
              hdr_cnt_nxt = hdr_cnt_r + HCNT_W'(1);
            end
          end
          PH_PAYLOAD: begin
            remaining_nxt      = rem_dec;
            push[0].out_byte   = in_data.data_byte;
            push[0].frame_last = (rem_dec == 32'd0);
            npush              = PUSH_W'(1);
            if (rem_dec == 32'd0) begin
              phase_nxt = PH_HEADER;
            end
          end
          PH_HALT: begin
            // drop the byte silently
          end
          default: begin
            phase_nxt   = PH_HEADER;
            hdr_cnt_nxt = '0;
          end
        endcase
      end
    end
  end

  // Advance the queue: pop the head, then append this cycle's results
  always_comb begin
    cnt_after = cnt_r - OUTQ_CW'(out_pop);
    for (int j = 0; j < OUTQ_DEPTH; j++) begin
      if (out_pop && (j < OUTQ_DEPTH - 1)) begin
        q_nxt[j] = q_r[j+1];
      end else begin
        q_nxt[j] = q_r[j];
      end
    end
    for (int j = 0; j < OUTQ_DEPTH; j++) begin
      if ((OUTQ_CW'(j) >= cnt_after) &&
          ((OUTQ_CW'(j) - cnt_after) < OUTQ_CW'(npush))) begin
        q_nxt[j] = push[HCNT_W'(OUTQ_CW'(j) - cnt_after)];
      end
    end
    cnt_nxt = cnt_after + OUTQ_CW'(npush);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      cnt_r     <= '0;
      max_len_r <= MAX_LEN_RST;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    remaining_r <= remaining_nxt;
    if (hdr_we) begin
      hdr_r[hdr_cnt_r] <= in_data.data_byte;
    end
    for (int j = 0; j < OUTQ_DEPTH; j++) begin
      q_r[j] <= q_nxt[j];
    end
  end

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OUTQ_CW'(OUTQ_DEPTH))
    else $error("output queue overfilled");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_data.restart && phase_r == PH_HALT) |=> cnt_r <= $past(cnt_r))
    else $error("halted block produced a result");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.restart) |=> (phase_r == PH_HEADER && hdr_cnt_r == '0))
    else $error("restart did not clear the frame");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remaining_r != 32'd0)
    else $error("payload phase with nothing left");

endmodule
